[hdl/multi_button_debounce_key_latch_core_macros.svh]
// Assertion helpers for the checker of this block.
`ifndef MULTI_BUTTON_DEBOUNCE_KEY_LATCH_CORE_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_KEY_LATCH_CORE_MACROS_SVH

// Same-cycle implication.
`define MBDK_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MBDK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mbdk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbdk_pkg;

   localparam int BUTTONS  = 4;
   localparam int KEYS     = 4;
   localparam int CNT_W    = 16;
   localparam int KEY_W    = 8;
   localparam int LEVEL_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [KEY_W-1:0]   RELEASE_OFFSET = 8'd32;
   localparam logic [CNT_W-1:0]   RST_DEBOUNCE   = 16'd20;
   localparam logic [KEY_W-1:0]   RST_KEY_ZERO   = 8'd97;   // 'a'
   localparam logic [KEY_W-1:0]   RST_KEY_ONE    = 8'd100;  // 'd'
   localparam logic [KEY_W-1:0]   RST_KEY_TWO    = 8'd119;  // 'w'
   localparam logic [KEY_W-1:0]   RST_KEY_THREE  = 8'd98;   // 'b'

   // Request kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODE_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODE_ONE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODE_TWO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_CODE_THREE = 3'd4;

   typedef struct packed {
      logic               kind;
      logic [LEVEL_W-1:0] button_levels;
   } req_payload_type;

   typedef struct packed {
      logic [KEY_W-1:0]   read_data;
      logic               event_pulse;
      logic [KEY_W-1:0]   event_key;
      logic [LEVEL_W-1:0] pressed_mask;
   } rsp_payload_type;

   // Per-lane update strobes
   typedef struct packed {
      logic prime;   // first tick: take pressed flag from level
      logic tick;    // normal debounce tick
   } lane_ctrl_type;

   // Per-lane result of the current tick
   typedef struct packed {
      logic pressed_next;
      logic fire;          // press or release detected
      logic is_release;
   } lane_status_type;

endpackage

`default_nettype wire

[hdl/multi_button_debounce_key_latch_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// req_    | in        | req_valid/req_stall | kind, button_levels
// rsp_    | out       | rsp_valid/rsp_stall | read_data, event_pulse, event_key, pressed_mask
// csr_    | in        | csr_write           | csr_index, csr_wdata
//
// A request is held in the input register; its response is then loaded into
// the response register, from which it leaves. A new request is taken every
// cycle while the response side keeps up. Reset clears all valid bits, the
// button state, the key latch and loads the register defaults. A stalled
// response holds both stages; req_stall rises only when the input register
// is full and the response register cannot drain.
module multi_button_debounce_key_latch_core
   import mbdk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire req_payload_type       req_payload,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      rsp_payload_type       rsp_payload,

   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [CNT_W-1:0] debounce_ff;
   logic [KEY_W-1:0] key_code_ff [KEYS];

   // Pipeline registers
   logic             s1_valid_ff;
   req_payload_type  s1_item_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   // Block state outside the lanes
   logic             primed_ff, primed_in;
   logic [KEY_W-1:0] latched_ff, latched_in;

   logic             out_ready;    // response register can take a new request
   logic             proc_go;      // request in the input register is processed
   logic [CNT_W-1:0] reload;
   lane_ctrl_type    lane_ctrl;
   lane_status_type  lane_status [BUTTONS];

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // A zero debounce setting behaves as one tick.
   assign reload = (debounce_ff == '0) ? CNT_W'(1) : debounce_ff;

   assign lane_ctrl.prime = proc_go && (s1_item_ff.kind == KIND_TICK) && !primed_ff;
   assign lane_ctrl.tick  = proc_go && (s1_item_ff.kind == KIND_TICK) && primed_ff;

   for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
      mbdk_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .level  (s1_item_ff.button_levels[g]),
         .reload (reload),
         .status (lane_status[g])
      );
   end

   // Lowest firing button wins the latch; scan from the top down.
   always_comb begin
      logic             fired;
      logic [KEY_W-1:0] ev_key;
      logic [LEVEL_W-1:0] mask;
      fired  = 1'b0;
      ev_key = '0;
      mask   = '0;
      for (int i = BUTTONS - 1; i >= 0; i--) begin
         mask[i] = lane_status[i].pressed_next;
         if (lane_status[i].fire) begin
            fired  = 1'b1;
            ev_key = lane_status[i].is_release ? key_code_ff[i] - RELEASE_OFFSET
                                               : key_code_ff[i];
         end
      end

      primed_in   = primed_ff;
      latched_in  = latched_ff;
      rsp_data_in.read_data    = '0;
      rsp_data_in.event_pulse  = 1'b0;
      rsp_data_in.event_key    = '0;
      rsp_data_in.pressed_mask = mask;

      if (s1_item_ff.kind == KIND_READ) begin
         rsp_data_in.read_data = latched_ff;
         latched_in            = '0;
      end else if (!primed_ff) begin
         primed_in = 1'b1;
      end else if (fired) begin
         latched_in              = ev_key;
         rsp_data_in.event_pulse = 1'b1;
         rsp_data_in.event_key   = ev_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
         latched_ff   <= '0;
      end else begin
         if (!s1_valid_ff || out_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (proc_go) begin
            primed_ff  <= primed_in;
            latched_ff <= latched_in;
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (!s1_valid_ff || out_ready) begin
         s1_item_ff <= req_payload;
      end
      if (proc_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= RST_DEBOUNCE;
         key_code_ff[0] <= RST_KEY_ZERO;
         key_code_ff[1] <= RST_KEY_ONE;
         key_code_ff[2] <= RST_KEY_TWO;
         key_code_ff[3] <= RST_KEY_THREE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ff    <= csr_wdata[CNT_W-1:0];
            CSR_KEY_CODE_ZERO:  key_code_ff[0] <= csr_wdata[KEY_W-1:0];
            CSR_KEY_CODE_ONE:   key_code_ff[1] <= csr_wdata[KEY_W-1:0];
            CSR_KEY_CODE_TWO:   key_code_ff[2] <= csr_wdata[KEY_W-1:0];
            CSR_KEY_CODE_THREE: key_code_ff[3] <= csr_wdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

[hdl/mbdk_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// One button: edge detect, restart countdown, debounced pressed flag.
module mbdk_lane
   import mbdk_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lane_ctrl_type    ctrl,
   input  wire logic             level,
   input  wire logic [CNT_W-1:0] reload,
   output      lane_status_type  status
);

   logic             prev_ff, prev_in;
   logic             pressed_ff, pressed_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      logic [CNT_W-1:0] dec;
      logic             expired;
      dec          = cnt_ff - 1'b1;
      expired      = 1'b0;
      prev_in      = prev_ff;
      pressed_in   = pressed_ff;
      cnt_in       = cnt_ff;
      status.fire       = 1'b0;
      status.is_release = 1'b0;
      if (ctrl.prime) begin
         pressed_in = ~level;
         prev_in    = level;
      end else if (ctrl.tick) begin
         prev_in = level;
         if (level != prev_ff) begin
            cnt_in = reload;
         end else if (cnt_ff != '0) begin
            cnt_in  = dec;
            expired = (dec == '0);
         end
         if (expired) begin
            if (!level) begin
               if (!pressed_ff) begin
                  pressed_in  = 1'b1;
                  status.fire = 1'b1;
               end
               cnt_in = reload;     // re-check while held
            end else if (pressed_ff) begin
               pressed_in        = 1'b0;
               status.fire       = 1'b1;
               status.is_release = 1'b1;
            end
         end
      end
      status.pressed_next = pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b1;
         pressed_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         prev_ff    <= prev_in;
         pressed_ff <= pressed_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

`default_nettype wire

[hdl/mbdk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "multi_button_debounce_key_latch_core_macros.svh"

module mbdk_checker
   import mbdk_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   `MBDK_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   `MBDK_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled response changed")

   `MBDK_ASSERT_IMPLY(a_event_not_read, clock, reset, rsp_valid && rsp_payload.event_pulse, rsp_payload.read_data == '0, "event carries read data")

   `MBDK_ASSERT_IMPLY(a_key_needs_event, clock, reset, rsp_valid && !rsp_payload.event_pulse, rsp_payload.event_key == '0, "event key without event")

endmodule

bind multi_button_debounce_key_latch_core mbdk_checker u_mbdk_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[tb/multi_button_debounce_key_latch_core_test.sv]
`timescale 1ns / 1ps

// Regression bench for the four-button debouncer with key latch.
//
// Requests are tick items (raw active-low button levels) or host reads of
// the key latch. Every request yields exactly one response. The scoreboard
// class below keeps its own copy of the registers and the per-button state,
// predicts each response when its request is accepted, and checks responses
// in order as they leave the block.
//
// Stimulus runs in phases. Each phase after the first programs every register
// while the block is idle, then plays button gestures: a target level pattern,
// a few bouncing ticks on the way there, then a stable hold of random length
// in which the countdown may run out. A small share of the ticks are pure
// noise, and host reads are mixed in throughout.
module multi_button_debounce_key_latch_core_test;
   import mbdk_pkg::*;

   localparam int REQUEST_BUDGET = 1500;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;     // two pipeline stages plus margin

   // ------------------------------------------------------------------
   // Predictor and response checker
   // ------------------------------------------------------------------
   class key_report_scoreboard;
      logic [CNT_W-1:0]   debounce_ticks;
      logic [KEY_W-1:0]   key_code [BUTTONS];
      logic [LEVEL_W-1:0] pressed;
      logic [LEVEL_W-1:0] prev_levels;
      logic [CNT_W-1:0]   countdown [BUTTONS];
      logic [KEY_W-1:0]   latched_key;
      bit                 primed;
      rsp_payload_type    awaited_reports [$];
      int                 failures;
      int                 key_events;
      int                 host_reads;
      int                 checked;

      function void clear_state();
         debounce_ticks = RST_DEBOUNCE;
         key_code[0]    = RST_KEY_ZERO;
         key_code[1]    = RST_KEY_ONE;
         key_code[2]    = RST_KEY_TWO;
         key_code[3]    = RST_KEY_THREE;
         pressed        = '0;
         prev_levels    = '1;
         for (int i = 0; i < BUTTONS; i++) countdown[i] = '0;
         latched_key    = '0;
         primed         = 1'b0;
         awaited_reports.delete();
         failures       = 0;
         key_events     = 0;
         host_reads     = 0;
         checked        = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEBOUNCE_TICKS: debounce_ticks = data;
            CSR_KEY_CODE_ZERO:  key_code[0] = data[KEY_W-1:0];
            CSR_KEY_CODE_ONE:   key_code[1] = data[KEY_W-1:0];
            CSR_KEY_CODE_TWO:   key_code[2] = data[KEY_W-1:0];
            CSR_KEY_CODE_THREE: key_code[3] = data[KEY_W-1:0];
            default: ;          // unmapped index, no effect
         endcase
      endfunction

      // Advance the button state by one request and queue the response it owes.
      function void note_request(req_payload_type r);
         rsp_payload_type    e;
         logic [LEVEL_W-1:0] lane_mask;
         logic [LEVEL_W-1:0] lv;
         logic [LEVEL_W-1:0] edges;
         logic [CNT_W-1:0]   reload;
         bit                 fired;
         bit                 expired;
         e         = '0;
         lane_mask = LEVEL_W'((1 << BUTTONS) - 1);
         lv        = r.button_levels & lane_mask;
         reload    = (debounce_ticks == '0) ? CNT_W'(1) : debounce_ticks;
         if (r.kind == KIND_READ) begin
            e.read_data = latched_key;
            latched_key = '0;
            host_reads++;
         end else if (!primed) begin
            // first tick only seeds the flags
            pressed     = ~lv & lane_mask;
            prev_levels = lv;
            primed      = 1'b1;
         end else begin
            edges = lv ^ prev_levels;
            fired = 1'b0;
            for (int i = 0; i < BUTTONS; i++) begin
               expired = 1'b0;
               if (edges[i]) begin
                  countdown[i] = reload;   // edge wins over expiry
               end else if (countdown[i] != '0) begin
                  countdown[i] = countdown[i] - 1'b1;
                  expired = (countdown[i] == '0);
               end
               if (expired) begin
                  if (!lv[i]) begin
                     if (!pressed[i]) begin
                        pressed[i] = 1'b1;
                        if (!fired) begin
                           fired = 1'b1;
                           e.event_key = key_code[i];
                        end
                     end
                     countdown[i] = reload;   // keep re-checking while held
                  end else if (pressed[i]) begin
                     pressed[i] = 1'b0;
                     if (!fired) begin
                        fired = 1'b1;
                        e.event_key = key_code[i] - RELEASE_OFFSET;
                     end
                  end
               end
            end
            prev_levels = lv;
            if (fired) begin
               latched_key   = e.event_key;
               e.event_pulse = 1'b1;
               key_events++;
            end
         end
         e.pressed_mask = pressed & lane_mask;
         awaited_reports.push_back(e);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_reports.size() == 0) begin
            $error("response with nothing outstanding: %h", got);
            failures++;
         end else begin
            want = awaited_reports.pop_front();
            checked++;
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
               failures++;
            end
            if (got.event_pulse !== want.event_pulse) begin
               $error("event_pulse: expected %0b, got %0b", want.event_pulse, got.event_pulse);
               failures++;
            end
            if (got.event_key !== want.event_key) begin
               $error("event_key: expected %0d, got %0d", want.event_key, got.event_key);
               failures++;
            end
            if (got.pressed_mask !== want.pressed_mask) begin
               $error("pressed_mask: expected %b, got %b", want.pressed_mask, got.pressed_mask);
               failures++;
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, block
   // ------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_button_debounce_key_latch_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   key_report_scoreboard sb;
   int                   cycle_count = 0;
   int                   stall_clock = 0;
   int                   items_sent = 0;
   int                   burst_left = 0;
   int                   settings_used = 0;
   logic [LEVEL_W-1:0]   live_levels = '1;

   // Watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response-side backpressure. Rotates through: no stall, light random,
   // heavy random, and a fixed periodic pattern.
   always @(posedge clock) begin
      stall_clock <= stall_clock + 1;
      case ((stall_clock / 300) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= ($urandom_range(0, 99) < 70);
         default: rsp_stall <= ((stall_clock % 7) < 3);
      endcase
   end

   // Sample values as they stood before the edge; check in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one request and hold it until taken. The sender runs in bursts;
   // at the start of each burst it may idle before offering the request.
   task automatic send_request(input req_payload_type p);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(p);
      items_sent++;
      burst_left--;
   endtask

   task automatic send_read();
      req_payload_type p;
      p.kind          = KIND_READ;
      p.button_levels = LEVEL_W'($urandom);   // ignored on reads
      send_request(p);
   endtask

   // One tick; with_reads sprinkles host reads in front of some ticks.
   task automatic send_tick(input logic [LEVEL_W-1:0] lv, input bit with_reads);
      req_payload_type p;
      if (with_reads && $urandom_range(0, 99) < 15) send_read();
      p.kind          = KIND_TICK;
      p.button_levels = lv;
      send_request(p);
      live_levels = lv;
   endtask

   // Drop valid and let every outstanding response come back.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all five registers, plus one stray write to an unmapped index.
   // Key writes carry junk in the upper data bits, which must be ignored.
   task automatic program_settings(input logic [CNT_W-1:0] ticks,
                                   input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                                   input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      idx[0] = CSR_DEBOUNCE_TICKS;  val[0] = ticks;
      idx[1] = CSR_KEY_CODE_ZERO;   val[1] = {8'($urandom), k0};
      idx[2] = CSR_KEY_CODE_ONE;    val[2] = {8'($urandom), k1};
      idx[3] = CSR_KEY_CODE_TWO;    val[3] = {8'($urandom), k2};
      idx[4] = CSR_KEY_CODE_THREE;  val[4] = {8'($urandom), k3};
      idx[5] = CSR_KEY_CODE_THREE + CSR_IDX_W'($urandom_range(1, 3));
      val[5] = CSR_DATA_W'($urandom);
      for (int i = 0; i < 6; i++) begin
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_register(idx[i], val[i]);
      end
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Gestures: move toward a new level pattern, bounce a few ticks, then hold.
   task automatic play_gestures(input int count, input int hold_max);
      int                 stop_at;
      int                 bounce;
      int                 hold;
      logic [LEVEL_W-1:0] flip;
      logic [LEVEL_W-1:0] target;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 9) < 6) flip = LEVEL_W'(1 << $urandom_range(0, BUTTONS - 1));
            else flip = LEVEL_W'($urandom_range(1, 15));
            target = live_levels ^ flip;
            bounce = $urandom_range(0, 3);
            for (int k = 0; k < bounce; k++)
               send_tick(live_levels ^ (flip & LEVEL_W'($urandom)), 1'b1);
            hold = $urandom_range(1, hold_max);
            for (int k = 0; k < hold; k++) send_tick(target, 1'b1);
         end else begin
            send_tick(LEVEL_W'($urandom), 1'b1);   // noise
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int                ticks;
      logic [KEY_W-1:0]  keys [4];
      sb = new;
      sb.clear_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults. A read before the first tick must not prime the block;
      // the first tick then seeds the pressed flags without an event.
      send_read();
      send_tick(4'b1010, 1'b0);
      send_read();
      play_gestures(150, 26);   // holds long enough for the default countdown
      drain();

      // Zero debounce behaves as one; extreme key codes, release wrap-around.
      program_settings('0, 8'd0, 8'd255, 8'd31, 8'd32);
      send_tick(4'b1111, 1'b0);
      send_tick(4'b1111, 1'b0);
      send_tick(4'b1111, 1'b0);   // everything released by now
      send_tick(4'b1110, 1'b0);
      send_tick(4'b1110, 1'b0);   // button 0 press, key 0
      send_read();
      send_read();                // latch already cleared
      send_tick(4'b0000, 1'b0);
      send_tick(4'b0000, 1'b0);   // three presses at once, lowest index wins
      send_tick(4'b1111, 1'b0);
      send_tick(4'b1111, 1'b0);   // all release, key 0 wraps to 224
      send_read();
      send_tick(4'b1110, 1'b0);
      send_tick(4'b1111, 1'b0);   // edge lands on the expiry tick
      send_tick(4'b1111, 1'b0);
      send_tick(4'b0111, 1'b0);
      send_tick(4'b0111, 1'b0);   // button 3 press
      send_tick(4'b1111, 1'b0);
      send_tick(4'b1111, 1'b0);   // button 3 release, 32 - 32 = 0
      send_read();
      play_gestures(200, 4);
      drain();

      // Longest countdown: edges reload it, nothing should expire here.
      program_settings('1, 8'd255, 8'd0, 8'd128, 8'd127);
      play_gestures(40, 4);
      drain();

      // Shortest nonzero countdown.
      program_settings(CNT_W'(1), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      play_gestures(150, 3);
      drain();

      // Random settings until the request budget is spent; the last phase
      // only plays what is left of the budget.
      while (items_sent < REQUEST_BUDGET) begin
         if ($urandom_range(0, 4) == 0) ticks = $urandom_range(7, 24);
         else ticks = $urandom_range(1, 6);
         for (int i = 0; i < 4; i++) keys[i] = 8'($urandom);
         program_settings(CNT_W'(ticks), keys[0], keys[1], keys[2], keys[3]);
         play_gestures((REQUEST_BUDGET - items_sent < 220) ? REQUEST_BUDGET - items_sent : 220,
                       ticks + 3);
         drain();
      end

      $display("covered %0d requests: %0d host reads, %0d key events, %0d responses checked",
               items_sent, sb.host_reads, sb.key_events, sb.checked);
      $display("across %0d register settings, %0d cycles", settings_used, cycle_count);
      if (sb.failures == 0 && sb.awaited_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
